[rtl/vector_to_angle_octant_core_defines.svh]
// Assertion macros used by the top RTL file of the vector-to-angle core.
`ifndef VECTOR_TO_ANGLE_OCTANT_CORE_DEFINES_SVH
`define VECTOR_TO_ANGLE_OCTANT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define VTA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define VTA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define VTA_ASSERT_SAME(label, ante, cons)
`define VTA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/vta_pkg.sv]
`default_nettype none

package vta_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS       = 16;
    localparam int Q_BITS          = FRAC_BITS + 1;
    localparam int VALUE_WIDTH     = 19;
    localparam int ANGLE_SHIFT     = 5;
    localparam int ANGLE_WIDTH     = 14;
    localparam int OUT_TDATA_W     = 16;

    localparam logic [Q_BITS-1:0]      ONE_Q16 = Q_BITS'(1) << FRAC_BITS;
    localparam logic [VALUE_WIDTH-1:0] TWO_Q16 = VALUE_WIDTH'(2) << FRAC_BITS;

    typedef struct packed {
        logic       valid;
        logic       zero;
        logic [2:0] octant;
    } t_side;

endpackage

`default_nettype wire

[rtl/vector_to_angle_octant_core.sv]
// Channel  Direction  Data bits (lowest first)              Handshake
// s_axis   in         delta_x, delta_z (COORD_WIDTH each)    s_axis_tvalid / s_axis_tready
// m_axis   out        angle (14 bits, zero-padded to 16)     m_axis_tvalid / m_axis_tready
//
// One word is accepted per cycle while the output register is not stalled.
// Each word passes through two folding stages, one divider cell per quotient bit (17 cells)
// and the output register.
// Reset is synchronous and active low; it clears only the valid bits of the pipeline.
// A stalled output register freezes the whole pipeline and drops s_axis_tready.
`default_nettype none
`include "vector_to_angle_octant_core_defines.svh"

module vector_to_angle_octant_core #(
    parameter int COORD_WIDTH = vta_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: delta_x, delta_z, zero padding.
    input  wire logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // Fields from bit 0: angle, zero padding.
    output logic      [vta_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int NCELL = vta_pkg::Q_BITS;

    logic                                 w_en;
    vta_pkg::t_side                       w_side [0:NCELL];
    logic           [COORD_WIDTH:0]       w_rem  [0:NCELL];
    logic           [COORD_WIDTH-1:0]     w_big  [0:NCELL];
    logic           [vta_pkg::Q_BITS-1:0] w_quo  [0:NCELL];
    logic           [COORD_WIDTH-1:0]     w_small;

    logic [vta_pkg::Q_BITS-1:0]      w_ratio;
    logic [vta_pkg::VALUE_WIDTH-1:0] w_value;
    logic [vta_pkg::ANGLE_WIDTH-1:0] n_angle;
    logic [vta_pkg::ANGLE_WIDTH-1:0] r_angle;
    logic                            r_out_valid;

    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    vta_fold #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_fold (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (s_axis_tvalid),
        .i_delta_x (s_axis_tdata[COORD_WIDTH-1:0]),
        .i_delta_z (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .o_side    (w_side[0]),
        .o_small   (w_small),
        .o_big     (w_big[0])
    );

    assign w_rem[0] = {1'b0, w_small};
    assign w_quo[0] = '0;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        vta_div_cell #(
            .MAG_W (COORD_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_side  (w_side[g]),
            .i_rem   (w_rem[g]),
            .i_big   (w_big[g]),
            .i_quo   (w_quo[g]),
            .o_side  (w_side[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_big   (w_big[g+1]),
            .o_quo   (w_quo[g+1])
        );
    end

    always_comb begin
        w_ratio = w_side[NCELL].octant[0] ? (vta_pkg::ONE_Q16 - w_quo[NCELL]) : w_quo[NCELL];
        w_value = vta_pkg::TWO_Q16
                - {w_side[NCELL].octant, {vta_pkg::FRAC_BITS{1'b0}}}
                - {2'b00, w_ratio};
        n_angle = w_side[NCELL].zero ? '0
                : w_value[vta_pkg::ANGLE_SHIFT +: vta_pkg::ANGLE_WIDTH];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_side[NCELL].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_angle <= n_angle;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(vta_pkg::OUT_TDATA_W - vta_pkg::ANGLE_WIDTH){1'b0}}, r_angle};

    `VTA_ASSERT_SAME(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    `VTA_ASSERT_NEXT(a_word_enters_fold, s_axis_tvalid && s_axis_tready, u_fold.r_valid_a)
    `VTA_ASSERT_SAME(a_ratio_in_range, w_side[NCELL].valid && !w_side[NCELL].zero, w_quo[NCELL] <= vta_pkg::ONE_Q16)

endmodule

`default_nettype wire

[rtl/vta_fold.sv]
`default_nettype none

module vta_fold #(
    parameter int COORD_WIDTH = vta_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire logic [COORD_WIDTH-1:0] i_delta_x,
    input  wire logic [COORD_WIDTH-1:0] i_delta_z,
    output vta_pkg::t_side              o_side,
    output logic      [COORD_WIDTH-1:0] o_small,
    output logic      [COORD_WIDTH-1:0] o_big
);

    logic                   r_valid_a;
    logic                   r_neg_x;
    logic                   r_neg_z;
    logic [COORD_WIDTH-1:0] r_mag_x;
    logic [COORD_WIDTH-1:0] r_mag_z;
    logic [COORD_WIDTH-1:0] n_mag_x;
    logic [COORD_WIDTH-1:0] n_mag_z;

    vta_pkg::t_side         r_side;
    vta_pkg::t_side         n_side;
    logic [COORD_WIDTH-1:0] r_small;
    logic [COORD_WIDTH-1:0] r_big;
    logic [COORD_WIDTH-1:0] n_small;
    logic [COORD_WIDTH-1:0] n_big;
    logic                   w_mixed;
    logic                   w_lt;

    always_comb begin
        n_mag_x = i_delta_x[COORD_WIDTH-1] ? (~i_delta_x + COORD_WIDTH'(1)) : i_delta_x;
        n_mag_z = i_delta_z[COORD_WIDTH-1] ? (~i_delta_z + COORD_WIDTH'(1)) : i_delta_z;
    end

    always_comb begin
        w_mixed          = r_neg_x ^ r_neg_z;
        w_lt             = r_mag_x < r_mag_z;
        n_side.valid     = r_valid_a;
        n_side.zero      = (r_mag_x == '0) && (r_mag_z == '0);
        n_side.octant    = {r_neg_z, w_mixed, (w_lt ? ~w_mixed : w_mixed)};
        n_small          = w_lt ? r_mag_x : r_mag_z;
        n_big            = w_lt ? r_mag_z : r_mag_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a    <= 1'b0;
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_valid_a    <= i_valid;
            r_side.valid <= n_side.valid;
        end
        if (i_en) begin
            r_neg_x       <= i_delta_x[COORD_WIDTH-1];
            r_neg_z       <= i_delta_z[COORD_WIDTH-1];
            r_mag_x       <= n_mag_x;
            r_mag_z       <= n_mag_z;
            r_side.zero   <= n_side.zero;
            r_side.octant <= n_side.octant;
            r_small       <= n_small;
            r_big         <= n_big;
        end
    end

    assign o_side  = r_side;
    assign o_small = r_small;
    assign o_big   = r_big;

endmodule

`default_nettype wire

[rtl/vta_div_cell.sv]
`default_nettype none

module vta_div_cell #(
    parameter int MAG_W = vta_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire vta_pkg::t_side             i_side,
    input  wire logic [MAG_W:0]             i_rem,
    input  wire logic [MAG_W-1:0]           i_big,
    input  wire logic [vta_pkg::Q_BITS-1:0] i_quo,
    output vta_pkg::t_side                  o_side,
    output logic      [MAG_W:0]             o_rem,
    output logic      [MAG_W-1:0]           o_big,
    output logic      [vta_pkg::Q_BITS-1:0] o_quo
);

    logic [MAG_W:0]             w_big_x;
    logic [MAG_W:0]             w_diff;
    logic                       w_ge;
    logic [MAG_W:0]             w_keep;
    logic [MAG_W:0]             n_rem;
    logic [vta_pkg::Q_BITS-1:0] n_quo;

    vta_pkg::t_side             r_side;
    logic [MAG_W:0]             r_rem;
    logic [MAG_W-1:0]           r_big;
    logic [vta_pkg::Q_BITS-1:0] r_quo;

    // The kept remainder is below the divisor, so it fits MAG_W bits before the shift.
    always_comb begin
        w_big_x = {1'b0, i_big};
        w_diff  = i_rem - w_big_x;
        w_ge    = i_rem >= w_big_x;
        w_keep  = w_ge ? w_diff : i_rem;
        n_rem   = {w_keep[MAG_W-1:0], 1'b0};
        n_quo   = {i_quo[vta_pkg::Q_BITS-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side.valid <= i_side.valid;
        end
        if (i_en) begin
            r_side.zero   <= i_side.zero;
            r_side.octant <= i_side.octant;
            r_rem         <= n_rem;
            r_big         <= i_big;
            r_quo         <= n_quo;
        end
    end

    assign o_side = r_side;
    assign o_rem  = r_rem;
    assign o_big  = r_big;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire
